FILE: rtl/core/lli_pkg.sv
// Shared types and constants for the line-line intersection pipeline.
package lli_pkg;

    localparam int COORD_W = 32;
    localparam int QBITS   = 42;          // quotient bits kept after the overflow pre-check
    localparam int PROD_W  = 96;          // |m| * |n| product width
    localparam int DM_W    = 64;          // |den| width
    localparam logic [QBITS:0] SAT_LIM = (QBITS+1)'(64'd1 << 40);

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] base;
        logic                      neg;
        logic                      byp;   // coordinate taken as-is from base
        logic                      ovf;   // quotient already known too large
        logic [DM_W-1:0]           dm;
        logic [DM_W-1:0]           rem;
        logic [QBITS-1:0]          pq;    // dividend bits out at top, quotient bits in at bottom
    } lane_t;

    typedef struct packed {
        lane_t x;
        lane_t y;
        logic  none;
    } div_t;

endpackage

FILE: rtl/core/line_line_intersect_2d_top.sv
// Top level: two-line crossing point as a pipeline of division cells.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: 8 x 32-bit Q16.16 line operands
//  m_*      out  m_tvalid/m_tready  m_tdata: status, cross_x, cross_y
//
// One beat per cycle in and out while m_tready stays high; 6 front stages,
// 42 quotient cells and 2 back stages. Each stage holds one beat and is
// enabled when empty or when the next stage moves, so bubbles close up.
// rst_n clears all stage valids; payload registers are not reset.
module line_line_intersect_2d_top
    import lli_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_point_x, a_point_y, a_dir_x, a_dir_y, b_point_x, b_point_y, b_dir_x, b_dir_y
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], cross_x[33:2], cross_y[65:34], zero pad[71:66]
    output logic [71:0]  m_tdata
);

    div_t chain_data  [QBITS+1];
    logic chain_valid [QBITS+1];
    logic chain_ready [QBITS+1];

    logic [1:0]  status;
    logic [31:0] cross_x, cross_y;

    lli_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar k = 0; k < QBITS; k++)
    begin : g_cell
        lli_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    lli_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[QBITS]),
        .in_ready  (chain_ready[QBITS]),
        .in_data   (chain_data[QBITS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cross_x   (cross_x),
        .cross_y   (cross_y)
    );

    assign m_tdata = {6'd0, cross_y, cross_x, status};

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status == ST_NONE) |-> (cross_x == 0 && cross_y == 0))
        else $error("no-crossing beat with nonzero point");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status == ST_FOUND || status == ST_NONE || status == ST_SAT))
        else $error("bad status code");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("pipeline stalled with empty output");

endmodule

FILE: rtl/core/lli_front.sv
// Front end: case decode, products, operand magnitudes and the m*n product.
module lli_front
    import lli_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [255:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output div_t         out_data
);

    typedef enum logic [2:0] {CASE_NONE, CASE_AV, CASE_BV, CASE_AH, CASE_BH, CASE_GEN} case_t;

    // stage A: input beat
    logic signed [31:0] apx_reg, apy_reg, adx_reg, ady_reg;
    logic signed [31:0] bpx_reg, bpy_reg, bdx_reg, bdy_reg;
    logic               va_reg;
    // stage B: decode and products
    case_t              code_reg;
    logic signed [31:0] bbase_reg [2];
    logic signed [31:0] bm_reg    [2];
    logic signed [31:0] bd_reg    [2];
    logic signed [32:0] bn_reg    [2];
    logic               bbyp_reg  [2];
    logic signed [63:0] dp1_reg, dp2_reg;
    logic signed [64:0] p1_reg, p2_reg;
    logic               vb_reg;
    // stage C: den and num
    logic signed [31:0] cbase_reg [2];
    logic signed [31:0] cm_reg    [2];
    logic signed [64:0] cd_reg    [2];
    logic signed [65:0] cn_reg    [2];
    logic               cbyp_reg  [2];
    logic               cnone_reg;
    logic               vc_reg;
    // stage D: magnitudes
    logic signed [31:0] dbase_reg [2];
    logic [31:0]        dmm_reg   [2];
    logic [64:0]        dnm_reg   [2];
    logic [63:0]        ddm_reg   [2];
    logic               dneg_reg  [2];
    logic               dbyp_reg  [2];
    logic               dnone_reg;
    logic               vd_reg;
    // stage E: partial products
    logic signed [31:0] ebase_reg [2];
    logic [64:0]        pp0_reg   [2];
    logic [63:0]        pp1_reg   [2];
    logic [63:0]        edm_reg   [2];
    logic               eneg_reg  [2];
    logic               ebyp_reg  [2];
    logic               enone_reg;
    logic               ve_reg;
    // stage F: output
    div_t               f_reg;
    logic               vf_reg;

    logic en_a, en_b, en_c, en_d, en_e, en_f;

    assign en_f = !vf_reg || out_ready;
    assign en_e = !ve_reg || en_f;
    assign en_d = !vd_reg || en_e;
    assign en_c = !vc_reg || en_d;
    assign en_b = !vb_reg || en_c;
    assign en_a = !va_reg || en_b;
    assign in_ready  = en_a;
    assign out_valid = vf_reg;
    assign out_data  = f_reg;

    // stage B combinational
    case_t              code_next;
    logic signed [32:0] wx, wy;
    logic signed [31:0] base_next [2];
    logic signed [31:0] m_next    [2];
    logic signed [31:0] d_next    [2];
    logic signed [32:0] n_next    [2];
    logic               byp_next  [2];

    always_comb
    begin
        wx = 33'(bpx_reg) - 33'(apx_reg);
        wy = 33'(bpy_reg) - 33'(apy_reg);
        if (adx_reg == 0 && bdx_reg == 0)
            code_next = CASE_NONE;
        else if (adx_reg == 0)
            code_next = CASE_AV;
        else if (bdx_reg == 0)
            code_next = CASE_BV;
        else if (ady_reg == 0)
            code_next = (bdy_reg == 0) ? CASE_NONE : CASE_AH;
        else if (bdy_reg == 0)
            code_next = CASE_BH;
        else
            code_next = CASE_GEN;
        for (int i = 0; i < 2; i++)
        begin
            m_next[i]   = '0;
            d_next[i]   = 32'sd1;
            n_next[i]   = '0;
            byp_next[i] = 1'b0;
        end
        base_next[0] = apx_reg;
        base_next[1] = apy_reg;
        case (code_next)
            CASE_AV:
            begin
                byp_next[0] = 1'b1;
                base_next[1] = bpy_reg; m_next[1] = bdy_reg; n_next[1] = -wx; d_next[1] = bdx_reg;
            end
            CASE_BV:
            begin
                byp_next[0] = 1'b1; base_next[0] = bpx_reg;
                m_next[1] = ady_reg; n_next[1] = wx; d_next[1] = adx_reg;
            end
            CASE_AH:
            begin
                base_next[0] = bpx_reg; m_next[0] = bdx_reg; n_next[0] = -wy; d_next[0] = bdy_reg;
                byp_next[1] = 1'b1;
            end
            CASE_BH:
            begin
                m_next[0] = adx_reg; n_next[0] = wy; d_next[0] = ady_reg;
                byp_next[1] = 1'b1; base_next[1] = bpy_reg;
            end
            CASE_GEN:
            begin
                m_next[0] = adx_reg;
                m_next[1] = ady_reg;
            end
            default:
            begin
                byp_next[0] = 1'b1;
                byp_next[1] = 1'b1;
            end
        endcase
    end

    // stage C combinational
    logic signed [64:0] den;
    logic signed [65:0] num;
    always_comb
    begin
        den = 65'(dp1_reg) - 65'(dp2_reg);
        num = 66'(p1_reg) - 66'(p2_reg);
    end

    // stage D combinational
    logic signed [64:0] negd  [2];
    logic signed [65:0] negn  [2];
    logic signed [31:0] negm  [2];
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            negd[i] = -cd_reg[i];
            negn[i] = -cn_reg[i];
            negm[i] = -cm_reg[i];
        end
    end

    // stage F combinational
    logic [PROD_W-1:0] prod [2];
    always_comb
    begin
        for (int i = 0; i < 2; i++)
            prod[i] = {31'd0, pp0_reg[i]} + {pp1_reg[i][62:0], 33'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else
        begin
            if (en_a) va_reg <= in_valid;
            if (en_b) vb_reg <= va_reg;
            if (en_c) vc_reg <= vb_reg;
            if (en_d) vd_reg <= vc_reg;
            if (en_e) ve_reg <= vd_reg;
            if (en_f) vf_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && in_valid)
        begin
            apx_reg <= in_data[31:0];
            apy_reg <= in_data[63:32];
            adx_reg <= in_data[95:64];
            ady_reg <= in_data[127:96];
            bpx_reg <= in_data[159:128];
            bpy_reg <= in_data[191:160];
            bdx_reg <= in_data[223:192];
            bdy_reg <= in_data[255:224];
        end
        if (en_b && va_reg)
        begin
            code_reg <= code_next;
            for (int i = 0; i < 2; i++)
            begin
                bbase_reg[i] <= base_next[i];
                bm_reg[i]    <= m_next[i];
                bd_reg[i]    <= d_next[i];
                bn_reg[i]    <= n_next[i];
                bbyp_reg[i]  <= byp_next[i];
            end
            dp1_reg <= adx_reg * bdy_reg;
            dp2_reg <= ady_reg * bdx_reg;
            p1_reg  <= wx * 33'(bdy_reg);
            p2_reg  <= wy * 33'(bdx_reg);
        end
        if (en_c && vb_reg)
        begin
            for (int i = 0; i < 2; i++)
            begin
                cbase_reg[i] <= bbase_reg[i];
                cm_reg[i]    <= bm_reg[i];
                cbyp_reg[i]  <= bbyp_reg[i];
                cd_reg[i]    <= (code_reg == CASE_GEN) ? den : 65'(bd_reg[i]);
                cn_reg[i]    <= (code_reg == CASE_GEN) ? num : 66'(bn_reg[i]);
            end
            cnone_reg <= (code_reg == CASE_NONE) || (code_reg == CASE_GEN && den == 0);
        end
        if (en_d && vc_reg)
        begin
            for (int i = 0; i < 2; i++)
            begin
                dbase_reg[i] <= cbase_reg[i];
                dbyp_reg[i]  <= cbyp_reg[i];
                dmm_reg[i]   <= cm_reg[i][31] ? negm[i] : cm_reg[i];
                dnm_reg[i]   <= cn_reg[i][65] ? negn[i][64:0] : cn_reg[i][64:0];
                ddm_reg[i]   <= cd_reg[i][64] ? negd[i][63:0] : cd_reg[i][63:0];
                dneg_reg[i]  <= cm_reg[i][31] ^ cn_reg[i][65] ^ cd_reg[i][64];
            end
            dnone_reg <= cnone_reg;
        end
        if (en_e && vd_reg)
        begin
            for (int i = 0; i < 2; i++)
            begin
                ebase_reg[i] <= dbase_reg[i];
                ebyp_reg[i]  <= dbyp_reg[i];
                eneg_reg[i]  <= dneg_reg[i];
                edm_reg[i]   <= ddm_reg[i];
                pp0_reg[i]   <= dmm_reg[i] * dnm_reg[i][32:0];
                pp1_reg[i]   <= dmm_reg[i] * dnm_reg[i][64:33];
            end
            enone_reg <= dnone_reg;
        end
        if (en_f && ve_reg)
        begin
            // quotient >= 2^QBITS exactly when the top dividend bits reach the divisor
            f_reg.x.base <= ebase_reg[0];
            f_reg.x.neg  <= eneg_reg[0];
            f_reg.x.byp  <= ebyp_reg[0];
            f_reg.x.ovf  <= {10'd0, prod[0][PROD_W-1:QBITS]} >= edm_reg[0];
            f_reg.x.dm   <= edm_reg[0];
            f_reg.x.rem  <= {10'd0, prod[0][PROD_W-1:QBITS]};
            f_reg.x.pq   <= prod[0][QBITS-1:0];
            f_reg.y.base <= ebase_reg[1];
            f_reg.y.neg  <= eneg_reg[1];
            f_reg.y.byp  <= ebyp_reg[1];
            f_reg.y.ovf  <= {10'd0, prod[1][PROD_W-1:QBITS]} >= edm_reg[1];
            f_reg.y.dm   <= edm_reg[1];
            f_reg.y.rem  <= {10'd0, prod[1][PROD_W-1:QBITS]};
            f_reg.y.pq   <= prod[1][QBITS-1:0];
            f_reg.none   <= enone_reg;
        end
    end

endmodule

FILE: rtl/core/lli_div_cell.sv
// One restoring-division cell: one quotient bit for each coordinate lane.
module lli_div_cell
    import lli_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  div_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output div_t out_data
);

    div_t data_reg;
    logic valid_reg;
    logic en;

    function automatic lane_t lane_step(input lane_t l);
        lane_t           r;
        logic [DM_W:0]   sh;
        logic [DM_W:0]   diff;
        r    = l;
        sh   = {l.rem, l.pq[QBITS-1]};
        diff = sh - {1'b0, l.dm};
        if (!diff[DM_W])
        begin
            r.rem = diff[DM_W-1:0];
            r.pq  = {l.pq[QBITS-2:0], 1'b1};
        end
        else
        begin
            r.rem = sh[DM_W-1:0];
            r.pq  = {l.pq[QBITS-2:0], 1'b0};
        end
        return r;
    endfunction

    assign en        = !valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            data_reg.x    <= lane_step(in_data.x);
            data_reg.y    <= lane_step(in_data.y);
            data_reg.none <= in_data.none;
        end
    end

endmodule

FILE: rtl/core/lli_back.sv
// Back end: round to nearest, add to base point, saturate, output register.
module lli_back
    import lli_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  div_t        in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] cross_x,
    output logic [31:0] cross_y
);

    logic               vg_reg;
    logic signed [31:0] gbase_reg [2];
    logic [40:0]        gq_reg    [2];
    logic               gneg_reg  [2];
    logic               gbyp_reg  [2];
    logic               gsat_reg  [2];
    logic               gnone_reg;

    logic               vh_reg;
    logic [1:0]         status_reg;
    logic [31:0]        x_reg, y_reg;

    logic en_g, en_h;
    assign en_h     = !vh_reg || out_ready;
    assign en_g     = !vg_reg || en_h;
    assign in_ready = en_g;
    assign out_valid = vh_reg;
    assign status   = status_reg;
    assign cross_x  = x_reg;
    assign cross_y  = y_reg;

    lane_t        ln    [2];
    logic [DM_W-1:0] half [2];
    logic [QBITS:0] q1  [2];

    always_comb
    begin
        ln[0] = in_data.x;
        ln[1] = in_data.y;
        for (int i = 0; i < 2; i++)
        begin
            half[i] = ln[i].dm - ln[i].rem;
            q1[i]   = {1'b0, ln[i].pq} + (QBITS+1)'(ln[i].rem >= half[i]);
        end
    end

    logic signed [42:0] v    [2];
    logic [31:0]        res  [2];
    logic               sat  [2];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            v[i] = gneg_reg[i] ? 43'(gbase_reg[i]) - $signed({2'b00, gq_reg[i]})
                               : 43'(gbase_reg[i]) + $signed({2'b00, gq_reg[i]});
            sat[i] = 1'b0;
            if (gbyp_reg[i])
                res[i] = gbase_reg[i];
            else if (gsat_reg[i])
            begin
                sat[i] = 1'b1;
                res[i] = gneg_reg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else if (!v[i][42] && (|v[i][41:31]))
            begin
                sat[i] = 1'b1;
                res[i] = 32'h7FFF_FFFF;
            end
            else if (v[i][42] && !(&v[i][41:31]))
            begin
                sat[i] = 1'b1;
                res[i] = 32'h8000_0000;
            end
            else
                res[i] = v[i][31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
        end
        else
        begin
            if (en_g) vg_reg <= in_valid;
            if (en_h) vh_reg <= vg_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_g && in_valid)
        begin
            for (int i = 0; i < 2; i++)
            begin
                gbase_reg[i] <= ln[i].base;
                gneg_reg[i]  <= ln[i].neg;
                gbyp_reg[i]  <= ln[i].byp;
                gq_reg[i]    <= q1[i][40:0];
                gsat_reg[i]  <= ln[i].ovf || (q1[i] > SAT_LIM);
            end
            gnone_reg <= in_data.none;
        end
        if (en_h && vg_reg)
        begin
            if (gnone_reg)
            begin
                status_reg <= ST_NONE;
                x_reg      <= '0;
                y_reg      <= '0;
            end
            else
            begin
                status_reg <= (sat[0] || sat[1]) ? ST_SAT : ST_FOUND;
                x_reg      <= res[0];
                y_reg      <= res[1];
            end
        end
    end

endmodule

FILE: verif/tb_line_line_intersect_2d_top.sv
// Testbench for the line-line intersection pipeline: random and corner line pairs vs. a predictor.
module tb_line_line_intersect_2d_top;
    import lli_pkg::*;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } crossing_t;

    class crossing_scoreboard;
        crossing_t pending[$];
        int        errors;

        // exact base + round(m*n/d), ties away from zero, with the 2^40 quotient guard
        function automatic logic signed [31:0] place(logic signed [63:0] base,
                logic signed [127:0] m, logic signed [127:0] n,
                logic signed [127:0] d, ref bit sat);
            logic signed [127:0] prod;
            logic [127:0]        pm;
            logic [127:0]        dm;
            logic [127:0]        q;
            logic [127:0]        r;
            logic signed [127:0] v;
            bit                  neg;
            prod = m * n;
            neg  = (prod < 0) != (d < 0);
            pm   = prod < 0 ? -prod : prod;
            dm   = d < 0 ? -d : d;
            q    = pm / dm;
            r    = pm % dm;
            if (r >= dm - r)
                q = q + 1;
            if (q > (128'd1 << 40))
            begin
                sat = 1;
                return neg ? 32'sh80000000 : 32'sh7fffffff;
            end
            v = neg ? base - $signed(q) : base + $signed(q);
            if (v > 128'sh7fffffff)
            begin
                sat = 1;
                return 32'sh7fffffff;
            end
            if (v < -128'sh80000000)
            begin
                sat = 1;
                return 32'sh80000000;
            end
            return v[31:0];
        endfunction

        function void note_lines(logic [255:0] d);
            logic signed [63:0]  apx, apy, adx, ady, bpx, bpy, bdx, bdy;
            logic signed [127:0] den;
            logic signed [127:0] num;
            crossing_t           c;
            bit                  sat;
            bit                  found;
            apx = $signed(d[31:0]);    apy = $signed(d[63:32]);
            adx = $signed(d[95:64]);   ady = $signed(d[127:96]);
            bpx = $signed(d[159:128]); bpy = $signed(d[191:160]);
            bdx = $signed(d[223:192]); bdy = $signed(d[255:224]);
            sat = 0;
            found = 1;
            c = '0;
            if (adx == 0 && bdx == 0)
                found = 0;
            else if (adx == 0)
            begin
                c.x = apx[31:0];
                c.y = place(bpy, bdy, apx - bpx, bdx, sat);
            end
            else if (bdx == 0)
            begin
                c.x = bpx[31:0];
                c.y = place(apy, ady, bpx - apx, adx, sat);
            end
            else if (ady == 0)
            begin
                if (bdy == 0)
                    found = 0;
                else
                begin
                    c.y = apy[31:0];
                    c.x = place(bpx, bdx, apy - bpy, bdy, sat);
                end
            end
            else if (bdy == 0)
            begin
                c.y = bpy[31:0];
                c.x = place(apx, adx, bpy - apy, ady, sat);
            end
            else
            begin
                den = 128'(adx) * 128'(bdy) - 128'(ady) * 128'(bdx);
                if (den == 0)
                    found = 0;
                else
                begin
                    num = 128'(bpx - apx) * 128'(bdy) - 128'(bpy - apy) * 128'(bdx);
                    c.x = place(apx, adx, num, den, sat);
                    c.y = place(apy, ady, num, den, sat);
                end
            end
            if (!found)
                c = '{ST_NONE, 32'sd0, 32'sd0};
            else
                c.status = sat ? ST_SAT : ST_FOUND;
            pending.push_back(c);
        endfunction

        function void check_crossing(logic [71:0] d);
            crossing_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[1:0] !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, d[1:0]);
                errors++;
            end
            if (d[33:2] !== e.x)
            begin
                $error("cross_x: expected %h, got %h", e.x, d[33:2]);
                errors++;
            end
            if (d[65:34] !== e.y)
            begin
                $error("cross_y: expected %h, got %h", e.y, d[65:34]);
                errors++;
            end
        endfunction
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [71:0]  m_tdata;

    crossing_scoreboard sb = new();
    int  cycles = 0;
    bit  quiet = 0;     // no idling on either side
    int  hold = 0;      // receiver hold-off cycles left
    bit  sending_done = 0;

    always #2 clk = ~clk;

    line_line_intersect_2d_top dut (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_crossing(m_tdata);
        if (hold > 0)
        begin
            hold <= hold - 1;
            m_tready <= 0;
        end
        else
            m_tready <= rst_n && (quiet || $urandom_range(99) >= 31);
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h0;
            3: return $urandom_range(8) << 16;
            4: return -($urandom_range(8) << 16);
            5: return $signed(16'($urandom)) <<< $urandom_range(16);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [255:0] rand_lines();
        logic [31:0] f[8];
        logic [31:0] k;
        foreach (f[i])
            f[i] = rand_coord();
        case ($urandom_range(9))
            0: f[2] = 0;
            1: f[6] = 0;
            2: f[3] = 0;
            3: f[7] = 0;
            4:
            begin
                k = $urandom_range(4);
                f[6] = f[2] * k;
                f[7] = f[3] * k;
            end
            5:
            begin
                f[2] = 0;
                f[6] = 0;
            end
            default: ;
        endcase
        return {f[7], f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
    endfunction

    task automatic send_lines(logic [255:0] d);
        while (!quiet && $urandom_range(99) < 31)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_lines(d);
    endtask

    function automatic logic [255:0] lines(int apx, int apy, int adx, int ady,
                                           int bpx, int bpy, int bdx, int bdy);
        return {bdy, bdx, bpy, bpx, ady, adx, apy, apx};
    endfunction

    localparam int ONE = 1 << 16;

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_lines(lines(0, 0, 0, ONE, ONE, 0, 0, ONE));              // both vertical
        send_lines(lines(0, 0, 0, 0, ONE, 0, 0, 0));                  // zero directions
        send_lines(lines(ONE, 0, 0, ONE, 0, 0, ONE, ONE));            // first vertical
        send_lines(lines(0, 0, ONE, ONE, 3 * ONE, 0, 0, ONE));        // second vertical
        send_lines(lines(0, 2 * ONE, ONE, 0, 0, 0, ONE, 2 * ONE));    // first horizontal
        send_lines(lines(0, 0, ONE, 0, 0, ONE, ONE, 0));              // both horizontal
        send_lines(lines(0, 0, ONE, ONE, 0, 5 * ONE, ONE, 0));        // second horizontal
        send_lines(lines(0, 0, ONE, 2 * ONE, ONE, 0, ONE, -ONE));     // general
        send_lines(lines(0, 0, ONE, ONE, ONE, 0, 2 * ONE, 2 * ONE));  // equal slopes
        send_lines(lines(0, 0, 3, 1, 0, 1, 3, -1));                   // rounding tie
        send_lines(lines(0, 0, 3, -1, 0, -1, 3, 1));
        send_lines(lines(32'h7fffffff, 0, 1, 1, 32'h80000000, 0, 1, -1));
        send_lines(lines(32'h7fffffff, 32'h7fffffff, 0, 32'h7fffffff,
                         32'h80000000, 32'h80000000, 1, 32'h7fffffff));  // saturates
        send_lines({8{32'h80000000}});
        send_lines({8{32'h7fffffff}});
        send_lines({8{32'hffffffff}});
        send_lines(lines(0, 0, 1, 32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 1));
        for (int i = 0; i < 2000; i++)
        begin
            quiet = (i >= 600 && i < 900);
            if (i == 1200)
                hold = 300;
            send_lines(rand_lines());
        end
        s_tvalid <= 0;
        quiet = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
